FILE: design/u8ad_pkg.sv
// ----------------------------------------------------------------------------
// u8ad_pkg
// Shared types, Arabic code point ranges and UTF-8 lead byte decoding.
// ----------------------------------------------------------------------------
package u8ad_pkg;

  typedef logic [7:0]  text_byte_t;
  typedef logic [20:0] code_point_t;
  typedef logic [2:0]  seq_len_t;

  typedef struct packed {
    text_byte_t text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } scan_req_t;

  localparam code_point_t RANGE0_LO = 21'h000600;
  localparam code_point_t RANGE0_HI = 21'h0006FF;
  localparam code_point_t RANGE1_LO = 21'h000750;
  localparam code_point_t RANGE1_HI = 21'h00077F;
  localparam code_point_t RANGE2_LO = 21'h0008A0;
  localparam code_point_t RANGE2_HI = 21'h0008FF;
  localparam code_point_t RANGE3_LO = 21'h00FB50;
  localparam code_point_t RANGE3_HI = 21'h00FDFF;
  localparam code_point_t RANGE4_LO = 21'h00FE70;
  localparam code_point_t RANGE4_HI = 21'h00FEFF;

  localparam seq_len_t LEN_NONE  = 3'd0;
  localparam seq_len_t LEN_TWO   = 3'd2;
  localparam seq_len_t LEN_THREE = 3'd3;
  localparam seq_len_t LEN_FOUR  = 3'd4;

  function automatic seq_len_t lead_len(input text_byte_t b);
    seq_len_t n;
    n = LEN_NONE;
    if ((b & 8'hE0) == 8'hC0) begin
      n = LEN_TWO;
    end else if ((b & 8'hF0) == 8'hE0) begin
      n = LEN_THREE;
    end else if ((b & 8'hF8) == 8'hF0) begin
      n = LEN_FOUR;
    end
    return n;
  endfunction

endpackage

FILE: design/utf8_arabic_script_detector_unit.sv
// ----------------------------------------------------------------------------
// utf8_arabic_script_detector_unit
// Detects Arabic-script code points in a UTF-8 byte stream, one result a text.
// ----------------------------------------------------------------------------
// The block takes one text byte per transfer and accepts a new byte in every
// cycle while no final byte waits on an occupied result register. Each byte
// passes an input register and then combinational decode and range-check
// logic that updates the sequence state and, on the byte marked by in_tlast,
// loads the result register. The result transfer is offered from that
// register, and the input keeps flowing while a result waits on out_tready
// until the next final byte meets the occupied result register.
module utf8_arabic_script_detector_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] has_arabic, [7:1] zero
);

  logic            in_valid_r;
  u8ad_pkg::item_t item_r;
  logic            advance;
  logic            res_flag;

  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.text_byte   <= in_tdata;
      item_r.end_of_text <= in_tlast;
    end
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  u8ad_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item       (item_r),
    .advance    (advance),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_flag   (res_flag)
  );

  assign out_tdata = {7'd0, res_flag};

endmodule

FILE: design/u8ad_scan.sv
// ----------------------------------------------------------------------------
// u8ad_scan
// Scans up to four bytes as a complete short text and reports whether any
// fully present sequence decodes to a code point in an Arabic range.
// ----------------------------------------------------------------------------
module u8ad_scan (
  input  u8ad_pkg::scan_req_t req,
  output logic                hit
);

  logic [7:0]         pad [0:6];
  logic [7:0]         reach;
  u8ad_pkg::seq_len_t n;

  function automatic u8ad_pkg::code_point_t decode(
    input logic [7:0] b0,
    input logic [7:0] b1,
    input logic [7:0] b2,
    input logic [7:0] b3,
    input u8ad_pkg::seq_len_t len
  );
    u8ad_pkg::code_point_t cp;
    case (len)
      u8ad_pkg::LEN_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
      u8ad_pkg::LEN_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      u8ad_pkg::LEN_FOUR:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default:             cp = '0;
    endcase
    return cp;
  endfunction

  function automatic logic in_range(input u8ad_pkg::code_point_t cp);
    return (cp >= u8ad_pkg::RANGE0_LO && cp <= u8ad_pkg::RANGE0_HI) ||
           (cp >= u8ad_pkg::RANGE1_LO && cp <= u8ad_pkg::RANGE1_HI) ||
           (cp >= u8ad_pkg::RANGE2_LO && cp <= u8ad_pkg::RANGE2_HI) ||
           (cp >= u8ad_pkg::RANGE3_LO && cp <= u8ad_pkg::RANGE3_HI) ||
           (cp >= u8ad_pkg::RANGE4_LO && cp <= u8ad_pkg::RANGE4_HI);
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pad[k] = req.bytes[k];
    end
    for (int k = 4; k < 7; k++) begin
      pad[k] = '0;
    end
    reach    = '0;
    reach[0] = 1'b1;
    hit      = 1'b0;
    n        = u8ad_pkg::LEN_NONE;
    for (int p = 0; p < 4; p++) begin
      n = u8ad_pkg::lead_len(pad[p]);
      if (reach[p] && (4'(p) < {1'b0, req.len})) begin
        if ((n != u8ad_pkg::LEN_NONE) && ((4'(p) + {1'b0, n}) <= {1'b0, req.len})) begin
          if (in_range(decode(pad[p], pad[p+1], pad[p+2], pad[p+3], n))) begin
            hit = 1'b1;
          end
          reach[3'(p) + n] = 1'b1;
        end else begin
          reach[p+1] = 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/u8ad_core.sv
// ----------------------------------------------------------------------------
// u8ad_core
// Sequence state, sticky hit flag and the registered result stage.
// ----------------------------------------------------------------------------
module u8ad_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  u8ad_pkg::item_t item,
  output logic            advance,
  output logic            res_valid,
  input  logic            res_ready,
  output logic            res_flag
);

  logic [7:0]         held_r [0:2];
  logic [7:0]         held_nxt [0:2];
  logic [1:0]         cnt_r, cnt_nxt;
  u8ad_pkg::seq_len_t exp_r, exp_nxt;
  logic               found_r, found_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic               res_flag_r, res_flag_nxt;
  logic               res_free;
  logic               fire;
  logic               hit;
  u8ad_pkg::seq_len_t lead_n;
  u8ad_pkg::scan_req_t req;

  // Only a final byte needs the result register, so other bytes never wait.
  assign res_free = !res_valid_r || res_ready;
  assign advance  = !item.end_of_text || res_free;
  assign fire     = item_valid && advance;
  assign lead_n   = u8ad_pkg::lead_len(item.text_byte);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < 3 && 2'(k) < cnt_r) begin
        req.bytes[k] = held_r[k < 3 ? k : 0];
      end else if (3'(k) == {1'b0, cnt_r}) begin
        req.bytes[k] = item.text_byte;
      end else begin
        req.bytes[k] = '0;
      end
    end
    req.len = {1'b0, cnt_r} + 3'd1;
  end

  u8ad_scan u_scan (
    .req (req),
    .hit (hit)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      held_nxt[k] = held_r[k];
    end
    cnt_nxt       = cnt_r;
    exp_nxt       = exp_r;
    found_nxt     = found_r;
    res_valid_nxt = res_valid_r;
    res_flag_nxt  = res_flag_r;
    if (res_free) begin
      res_valid_nxt = 1'b0;
    end
    if (fire) begin
      if (item.end_of_text) begin
        res_valid_nxt = 1'b1;
        res_flag_nxt  = found_r || hit;
        cnt_nxt       = '0;
        exp_nxt       = u8ad_pkg::LEN_NONE;
        found_nxt     = 1'b0;
      end else if (exp_r == u8ad_pkg::LEN_NONE) begin
        if (lead_n != u8ad_pkg::LEN_NONE) begin
          held_nxt[0] = item.text_byte;
          cnt_nxt     = 2'd1;
          exp_nxt     = lead_n;
        end
      end else if (({1'b0, cnt_r} + 3'd1) >= exp_r) begin
        found_nxt = found_r || hit;
        cnt_nxt   = '0;
        exp_nxt   = u8ad_pkg::LEN_NONE;
      end else if (cnt_r != 2'd3) begin
        held_nxt[cnt_r] = item.text_byte;
        cnt_nxt         = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      held_r[k] <= held_nxt[k];
    end
    res_flag_r <= res_flag_nxt;
    if (!rst_n) begin
      cnt_r       <= '0;
      exp_r       <= u8ad_pkg::LEN_NONE;
      found_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      exp_r       <= exp_nxt;
      found_r     <= found_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_flag  = res_flag_r;

endmodule

FILE: test/utf8_arabic_script_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_arabic_script_detector_unit_tb
// Drives short UTF-8 texts into the detector and checks the per-text flag.
// A scoreboard decodes every accepted byte the way the block should and
// queues the flag that each final byte produces. Results are compared in
// order. The run mixes directed texts with random well-formed, truncated and
// noisy texts, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module utf8_arabic_script_detector_unit_tb;
  import u8ad_pkg::*;

  class arabic_text_scoreboard;
    logic [3:0][7:0] held;
    logic [1:0]      held_cnt;
    seq_len_t        seq_len;
    logic            hit_seen;
    logic [7:0]      flag_q [$];

    function new();
      clear_text();
    endfunction

    function void clear_text();
      held     = '0;
      held_cnt = '0;
      seq_len  = LEN_NONE;
      hit_seen = 1'b0;
    endfunction

    function seq_len_t lead_bytes(text_byte_t b);
      casez (b)
        8'b110?????: return LEN_TWO;
        8'b1110????: return LEN_THREE;
        8'b11110???: return LEN_FOUR;
        default:     return LEN_NONE;
      endcase
    endfunction

    function bit is_arabic(code_point_t cp);
      return (cp >= RANGE0_LO && cp <= RANGE0_HI) || (cp >= RANGE1_LO && cp <= RANGE1_HI) ||
             (cp >= RANGE2_LO && cp <= RANGE2_HI) || (cp >= RANGE3_LO && cp <= RANGE3_HI) ||
             (cp >= RANGE4_LO && cp <= RANGE4_HI);
    endfunction

    function code_point_t decode(logic [3:0][7:0] s, seq_len_t n);
      code_point_t cp;
      int          k;
      case (n)
        LEN_TWO:   cp = code_point_t'(s[0][4:0]);
        LEN_THREE: cp = code_point_t'(s[0][3:0]);
        default:   cp = code_point_t'(s[0][2:0]);
      endcase
      for (k = 1; k < int'(n); k++) begin
        cp = {cp[14:0], s[k][5:0]};
      end
      return cp;
    endfunction

    // A truncated text is rescanned from its first held byte; a lead without
    // enough bytes after it is skipped.
    function bit scan_tail(logic [3:0][7:0] t, int len);
      int       i;
      seq_len_t n;
      i = 0;
      while (i < len) begin
        n = lead_bytes(t[i]);
        if (n == LEN_NONE || i + int'(n) > len) begin
          i++;
        end else begin
          if (is_arabic(decode(t >> (8 * i), n))) return 1'b1;
          i += int'(n);
        end
      end
      return 1'b0;
    endfunction

    function void note_byte(text_byte_t b, logic last);
      logic [3:0][7:0] tail;
      int              len;
      int              k;
      seq_len_t        n;
      if (last) begin
        tail = '0;
        len  = 0;
        if (seq_len != LEN_NONE) begin
          for (k = 0; k < int'(held_cnt); k++) begin
            tail[len] = held[k];
            len++;
          end
        end
        tail[len] = b;
        len++;
        flag_q.push_back({7'd0, hit_seen | scan_tail(tail, len)});
        clear_text();
      end else if (seq_len == LEN_NONE) begin
        n = lead_bytes(b);
        if (n != LEN_NONE) begin
          held[0]  = b;
          held_cnt = 2'd1;
          seq_len  = n;
        end
      end else if (int'(held_cnt) + 1 >= int'(seq_len)) begin
        tail = held;
        tail[int'(seq_len) - 1] = b;
        if (is_arabic(decode(tail, seq_len))) hit_seen = 1'b1;
        held_cnt = '0;
        seq_len  = LEN_NONE;
      end else if (held_cnt < 2'd3) begin
        held[held_cnt] = b;
        held_cnt++;
      end
    endfunction

    function int pending();
      return flag_q.size();
    endfunction

    function bit check_flag(logic [7:0] got, output logic [7:0] want);
      want = flag_q.pop_front();
      return got === want;
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 255;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  arabic_text_scoreboard sb = new();
  text_byte_t  txt_q [$];
  logic [8:0]  directed_q [$];
  logic [7:0]  want_flag;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          mismatches     = 0;
  int          cycle_cnt      = 0;

  utf8_arabic_script_detector_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (sb.pending() == 0) begin
        report_mismatch($sformatf("result %02h with no text pending", out_tdata));
      end else if (!sb.check_flag(out_tdata, want_flag)) begin
        report_mismatch($sformatf("has_arabic %b pad %02h, expected %b",
                                  out_tdata[0], out_tdata[7:1], want_flag[0]));
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("utf8_arabic_script_detector_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic send_item(input text_byte_t b, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, last);
  endtask

  function automatic text_byte_t payload(logic [5:0] bits);
    text_byte_t p;
    p = {2'b10, bits};
    if ($urandom_range(9) == 0) p[7:6] = 2'($urandom_range(3));
    return p;
  endfunction

  function automatic void push_seq(code_point_t cp, seq_len_t n);
    case (n)
      LEN_TWO: begin
        txt_q.push_back({3'b110, cp[10:6]});
        txt_q.push_back(payload(cp[5:0]));
      end
      LEN_THREE: begin
        txt_q.push_back({4'b1110, cp[15:12]});
        txt_q.push_back(payload(cp[11:6]));
        txt_q.push_back(payload(cp[5:0]));
      end
      LEN_FOUR: begin
        txt_q.push_back({5'b11110, cp[20:18]});
        txt_q.push_back(payload(cp[17:12]));
        txt_q.push_back(payload(cp[11:6]));
        txt_q.push_back(payload(cp[5:0]));
      end
      default: txt_q.push_back({1'b0, cp[6:0]});
    endcase
  endfunction

  // Code points inside the Arabic ranges and just outside their edges.
  function automatic void push_arabic();
    code_point_t lo;
    code_point_t hi;
    code_point_t cp;
    seq_len_t    n;
    case ($urandom_range(4))
      0:       begin lo = RANGE0_LO; hi = RANGE0_HI; end
      1:       begin lo = RANGE1_LO; hi = RANGE1_HI; end
      2:       begin lo = RANGE2_LO; hi = RANGE2_HI; end
      3:       begin lo = RANGE3_LO; hi = RANGE3_HI; end
      default: begin lo = RANGE4_LO; hi = RANGE4_HI; end
    endcase
    case ($urandom_range(7))
      0:       cp = lo - code_point_t'(1);
      1:       cp = lo;
      2:       cp = hi;
      3:       cp = hi + code_point_t'(1);
      default: cp = lo + code_point_t'($urandom_range(int'(hi - lo)));
    endcase
    n = (cp < 21'h800) ? LEN_TWO : LEN_THREE;
    if ($urandom_range(7) == 0) n = LEN_FOUR;
    push_seq(cp, n);
  endfunction

  task automatic make_text();
    int tokens;
    int k;
    int drop;
    bit plain;
    txt_q.delete();
    plain  = ($urandom_range(2) == 0);
    tokens = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(1, 5);
    for (k = 0; k < tokens; k++) begin
      case ($urandom_range(9))
        0, 1, 2: push_seq(code_point_t'($urandom_range(127)), LEN_NONE);
        3, 4, 5: begin
          if (plain) push_seq(code_point_t'($urandom_range(127)), LEN_NONE);
          else push_arabic();
        end
        6:       push_seq(code_point_t'($urandom), LEN_TWO);
        7:       push_seq(code_point_t'($urandom), LEN_THREE);
        8:       push_seq(code_point_t'($urandom), LEN_FOUR);
        default: txt_q.push_back(text_byte_t'($urandom_range(255)));
      endcase
    end
    if ($urandom_range(3) == 0) begin
      drop = $urandom_range(1, 3);
      while (drop > 0 && txt_q.size() > 1) begin
        void'(txt_q.pop_back());
        drop--;
      end
    end
    if (txt_q.size() == 0) txt_q.push_back(text_byte_t'($urandom_range(255)));
  endtask

  initial begin
    int phase;
    int sent;
    int k;
    directed_q = '{9'h141,
                   9'h0D8, 9'h1A7,
                   9'h0F0, 9'h0D8, 9'h1A7,
                   9'h0D8, 9'h0D8, 9'h161,
                   9'h0FF, 9'h080, 9'h1C4,
                   9'h0EF, 9'h0BB, 9'h0BF, 9'h100,
                   9'h0DC, 9'h080, 9'h0EF, 9'h0BC, 9'h080, 9'h17F,
                   9'h0EF, 9'h0AD, 9'h190};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_q[k]) send_item(directed_q[k][7:0], directed_q[k][8]);
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        make_text();
        for (k = 0; k < txt_q.size(); k++) send_item(txt_q[k], k == txt_q.size() - 1);
        sent += txt_q.size();
      end
    end
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && sb.pending() == 0) begin
      $display("utf8_arabic_script_detector_unit_tb OK");
    end else begin
      $display("utf8_arabic_script_detector_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
